/* rtl/core/tssp_pkg.sv */
package tssp_pkg;

  localparam int unsigned NUM_SETTINGS = 12;
  localparam int unsigned SET_IDX_W    = 4;
  localparam int unsigned KEPT_SETTING = 4;

  localparam logic [7:0] TAG_END       = 8'h00;
  localparam logic [7:0] TAG_LONG_SKIP = 8'hFF;
  localparam logic [7:0] TAG_SETTING   = 8'h80;

  localparam logic [7:0] SETTING_DEFAULTS [NUM_SETTINGS] = '{
    8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF
  };

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SKIP,
    PH_TAG,
    PH_VALUE
  } phase_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       record_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] setting_0;
    logic [7:0] setting_1;
    logic [7:0] setting_2;
    logic [7:0] setting_3;
    logic [7:0] setting_4;
    logic [7:0] setting_5;
    logic [7:0] setting_6;
    logic [7:0] setting_7;
    logic [7:0] setting_8;
    logic [7:0] setting_9;
    logic [7:0] setting_10;
    logic [7:0] setting_11;
  } out_item_t;

endpackage

/* rtl/core/tagged_setting_stream_parser.sv */
// Tagged setting stream parser.
// Input channel (in_valid/in_ready/in_data) carries one record byte per item,
// with record_start set on the first header byte. Output channel
// (out_valid/out_ready/out_data) carries one item holding all twelve settings
// for each record that ends with a zero tag; other bytes produce nothing.
// Rate: one input item per cycle. Each byte is decoded by short logic in the
// cycle it is accepted and updates the parser state directly.
// Output: the settings item is registered and appears in out_data in the cycle
// after its terminating tag byte is accepted.
// Stall: a single output register holds a finished item. While it is full and
// out_ready is low, in_ready drops, since the next byte might end another
// record; when out_ready is high the register refills in the same cycle, so
// back-to-back records keep full rate.
// Reset (rst, synchronous, active high): parser goes idle and ignores bytes
// until record_start; settings return to their defaults with setting 4 zero;
// the output register empties.
// Setting 4 keeps its value across records; all others are reloaded on start.
module tagged_setting_stream_parser #(
  parameter int unsigned HEADER_BYTES = 4,
  parameter int unsigned LONG_SKIP    = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tssp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tssp_pkg::out_item_t  out_data
);

  localparam logic [2:0] HEADER_CNT = 3'(HEADER_BYTES);
  localparam logic [2:0] LONG_CNT   = 3'(LONG_SKIP);

  tssp_pkg::phase_t phase, phase_next;
  logic [2:0]       skip_count, skip_count_next;
  logic [6:0]       pending_index, pending_index_next;
  logic [7:0]       store      [tssp_pkg::NUM_SETTINGS];
  logic [7:0]       store_next [tssp_pkg::NUM_SETTINGS];
  logic [7:0]       store_eff  [tssp_pkg::NUM_SETTINGS];

  tssp_pkg::phase_t    phase_eff;
  logic                emit;
  logic                in_fire;
  tssp_pkg::out_item_t result;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Apply record start first: reload defaults, arm the header skip.
  always_comb begin
    logic [2:0] skip_eff;
    phase_eff = phase;
    skip_eff  = skip_count;
    for (int i = 0; i < tssp_pkg::NUM_SETTINGS; i++) begin
      if (in_data.record_start && i != tssp_pkg::KEPT_SETTING) begin
        store_eff[i] = tssp_pkg::SETTING_DEFAULTS[i];
      end else begin
        store_eff[i] = store[i];
      end
    end
    if (in_data.record_start) begin
      phase_eff = tssp_pkg::PH_SKIP;
      skip_eff  = HEADER_CNT;
    end
    // An empty skip falls straight through to tag position.
    if (phase_eff == tssp_pkg::PH_SKIP && skip_eff == 3'd0) begin
      phase_eff = tssp_pkg::PH_TAG;
    end

    // Next state.
    phase_next         = phase_eff;
    skip_count_next    = skip_eff;
    pending_index_next = pending_index;
    store_next         = store_eff;
    unique case (phase_eff)
      tssp_pkg::PH_SKIP: begin
        skip_count_next = skip_eff - 3'd1;
        if (skip_count_next == 3'd0) begin
          phase_next = tssp_pkg::PH_TAG;
        end
      end
      tssp_pkg::PH_VALUE: begin
        // Drop values aimed at unknown setting numbers.
        if (pending_index < 7'(tssp_pkg::NUM_SETTINGS)) begin
          store_next[pending_index[tssp_pkg::SET_IDX_W-1:0]] = in_data.stream_byte;
        end
        phase_next = tssp_pkg::PH_TAG;
      end
      tssp_pkg::PH_TAG: begin
        priority if (in_data.stream_byte == tssp_pkg::TAG_END) begin
          phase_next = tssp_pkg::PH_IDLE;
        end else if (in_data.stream_byte == tssp_pkg::TAG_LONG_SKIP) begin
          skip_count_next = LONG_CNT;
          phase_next = (LONG_CNT != 3'd0) ? tssp_pkg::PH_SKIP : tssp_pkg::PH_TAG;
        end else if (in_data.stream_byte < tssp_pkg::TAG_SETTING) begin
          skip_count_next = 3'd1;
          phase_next      = tssp_pkg::PH_SKIP;
        end else begin
          pending_index_next = 7'(in_data.stream_byte - tssp_pkg::TAG_SETTING);
          phase_next         = tssp_pkg::PH_VALUE;
        end
      end
      default: begin
        phase_next = tssp_pkg::PH_IDLE;
      end
    endcase
  end

  // Outputs of the decode: emit on a zero tag, with the settings as they stand.
  always_comb begin
    emit = (phase_eff == tssp_pkg::PH_TAG) && (in_data.stream_byte == tssp_pkg::TAG_END);
    result.setting_0  = store_eff[0];
    result.setting_1  = store_eff[1];
    result.setting_2  = store_eff[2];
    result.setting_3  = store_eff[3];
    result.setting_4  = store_eff[4];
    result.setting_5  = store_eff[5];
    result.setting_6  = store_eff[6];
    result.setting_7  = store_eff[7];
    result.setting_8  = store_eff[8];
    result.setting_9  = store_eff[9];
    result.setting_10 = store_eff[10];
    result.setting_11 = store_eff[11];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tssp_pkg::PH_IDLE;
      skip_count    <= 3'd0;
      pending_index <= 7'd0;
      for (int i = 0; i < tssp_pkg::NUM_SETTINGS; i++) begin
        store[i] <= (i == tssp_pkg::KEPT_SETTING) ? 8'h00 : tssp_pkg::SETTING_DEFAULTS[i];
      end
    end else if (in_fire) begin
      phase         <= phase_next;
      skip_count    <= skip_count_next;
      pending_index <= pending_index_next;
      store         <= store_next;
    end
  end

  // Output register: load on a finished record, clear when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_emit_goes_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire && emit |=> phase == tssp_pkg::PH_IDLE)
    else $error("parser not idle after record end");

  a_start_keeps_setting4: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.record_start |=> store[4] == $past(store[4]))
    else $error("record start changed setting 4");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == tssp_pkg::PH_SKIP |-> skip_count != 3'd0)
    else $error("skip phase with empty count");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output register");

  a_out_from_tag: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_fire && emit))
    else $error("output item without terminating tag");
`endif

endmodule
